/* src/berm_pkg.sv */
// ----------------------------------------------------------------------------
// berm_pkg: shared types and constants of the resistance meter
// register map, configuration bundle, tick command and result layouts
// ----------------------------------------------------------------------------
`default_nettype none

package berm_pkg;

    localparam int CODE_W     = 16;
    localparam int INTERVAL_W = 17;
    localparam int DELAY_W    = 16;
    localparam int LINE_RES_W = 20;
    localparam int RES_W      = 36;
    localparam int TS_W       = 32;
    localparam int ELAPSED_W  = 17;

    // magnitude of sense * line resistance stays below 2^35
    localparam int MAG_W      = RES_W - 1;
    localparam int DIV_STEPS  = MAG_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_BITS    = 3 + 2 * RES_W + 2 * CODE_W + TS_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int PADDR_W = 4;
    localparam int APB_W   = 32;

    localparam logic [INTERVAL_W-1:0] TOGGLE_RST   = INTERVAL_W'(781);
    localparam logic [DELAY_W-1:0]    DELAY_RST    = DELAY_W'(586);
    localparam logic [LINE_RES_W-1:0] LINE_RES_RST = LINE_RES_W'(10000);
    localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX  = '1;

    typedef enum logic [1:0] {
        REG_DC_MODE         = 2'd0,
        REG_TOGGLE_INTERVAL = 2'd1,
        REG_SAMPLE_DELAY    = 2'd2,
        REG_LINE_RES        = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                  dc_mode;
        logic [INTERVAL_W-1:0] toggle_interval;
        logic [DELAY_W-1:0]    sample_delay;
        logic [LINE_RES_W-1:0] line_resistance;
    } t_cfg;

    // one classified tick, handed from front to back
    typedef struct packed {
        logic              drive_a;
        logic              drive_b;
        logic              sample;
        logic [CODE_W-1:0] drop;
        logic [CODE_W-1:0] sense_one;
        logic [CODE_W-1:0] sense_two;
        logic [TS_W-1:0]   timestamp;
    } t_cmd;

    // result fields, last field in the lowest bits
    typedef struct packed {
        logic [TS_W-1:0]   timestamp;
        logic [CODE_W-1:0] sense_two_out;
        logic [CODE_W-1:0] sense_one_out;
        logic [RES_W-1:0]  res_two_milli;
        logic [RES_W-1:0]  res_one_milli;
        logic              divide_error;
        logic              drive_b;
        logic              drive_a;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_back_state;

    function automatic logic [CODE_W-1:0] code_mag(input logic [CODE_W-1:0] code);
        return code[CODE_W-1] ? (~code + CODE_W'(1)) : code;
    endfunction

endpackage

`default_nettype wire

/* src/berm_front.sv */
// ----------------------------------------------------------------------------
// berm_front: tick sequencer
// phase toggling, sample decision and timestamp for each accepted item
// ----------------------------------------------------------------------------
`default_nettype none

module berm_front import berm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [CODE_W-1:0] i_drop,
    input  wire logic [CODE_W-1:0] i_sense_one,
    input  wire logic [CODE_W-1:0] i_sense_two,
    input  wire logic              i_queue_full,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    logic [INTERVAL_W-1:0] r_icount, n_icount;
    logic                  r_pos, n_pos;
    logic                  r_started, n_started;
    logic                  r_done, n_done;
    logic [ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic                  r_first, n_first;
    logic [TS_W-1:0]       r_tsf, n_tsf;

    logic [INTERVAL_W:0]   w_next;
    logic                  w_toggle;
    logic                  w_sample;
    logic [ELAPSED_W-1:0]  w_el;
    logic [TS_W-1:0]       w_ts;

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        n_pos     = r_pos;
        n_started = r_started;
        n_done    = r_done;
        n_first   = r_first;
        w_el      = r_elapsed;

        w_next   = {1'b0, r_icount} + (INTERVAL_W + 1)'(1);
        w_toggle = w_next >= {1'b0, i_cfg.toggle_interval};
        n_icount = w_toggle ? '0 : w_next[INTERVAL_W-1:0];

        if (w_toggle) begin
            n_started = 1'b1;
            if (i_cfg.dc_mode) begin
                n_pos  = 1'b1;
                n_done = 1'b0;
            end else begin
                n_pos = !r_pos;
                if (!r_pos) begin
                    n_done = 1'b0;
                    w_el   = '0;
                end
            end
        end

        w_sample = !n_done && n_pos && (w_el >= {1'b0, i_cfg.sample_delay});

        // timestamp is zero on the first sample and counts from there
        w_ts  = r_first ? r_tsf : '0;
        n_tsf = r_tsf;
        if (w_sample) begin
            n_done  = 1'b1;
            n_first = 1'b1;
            n_tsf   = w_ts + TS_W'(1);
        end else if (r_first) begin
            n_tsf = r_tsf + TS_W'(1);
        end

        n_elapsed = (w_el != ELAPSED_MAX) ? w_el + ELAPSED_W'(1) : w_el;

        o_cmd.drive_a   = n_started && n_pos;
        o_cmd.drive_b   = n_started && !n_pos;
        o_cmd.sample    = w_sample;
        o_cmd.drop      = i_drop;
        o_cmd.sense_one = i_sense_one;
        o_cmd.sense_two = i_sense_two;
        o_cmd.timestamp = w_sample ? w_ts : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icount  <= '0;
            r_pos     <= 1'b0;
            r_started <= 1'b0;
            r_done    <= 1'b0;
            r_elapsed <= '0;
            r_first   <= 1'b0;
            r_tsf     <= '0;
        end else if (o_push) begin
            r_icount  <= n_icount;
            r_pos     <= n_pos;
            r_started <= n_started;
            r_done    <= n_done;
            r_elapsed <= n_elapsed;
            r_first   <= n_first;
            r_tsf     <= n_tsf;
        end
    end

`ifndef NO_ASSERTIONS
    // a sample is only ever taken while the bridge drives positive
    a_sample_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_cmd.sample |-> o_cmd.drive_a && !o_cmd.drive_b)
        else $error("sample outside positive phase");
`endif

endmodule

`default_nettype wire

/* src/berm_queue.sv */
// ----------------------------------------------------------------------------
// berm_queue: two-entry command queue
// decouples the tick sequencer from the resistance datapath
// ----------------------------------------------------------------------------
`default_nettype none

module berm_queue import berm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_data
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("queue overflow or underflow");
`endif

endmodule

`default_nettype wire

/* src/berm_back.sv */
// ----------------------------------------------------------------------------
// berm_back: resistance datapath and result register
// one multiply, then two restoring dividers sharing one step counter
// ----------------------------------------------------------------------------
`default_nettype none

module berm_back import berm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [LINE_RES_W-1:0] i_line_res,
    input  wire logic                  i_q_valid,
    input  wire t_cmd                  i_q_data,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_res                       o_res,
    output logic                       o_sample
);

    t_back_state       r_state, n_state;
    t_cmd              r_cmd;
    logic [MAG_W-1:0]  r_dvd1, r_dvd2;
    logic [CODE_W-1:0] r_rem1, r_rem2;
    logic [CODE_W-1:0] r_dvs;
    logic              r_neg1, r_neg2;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_res              r_out;
    logic              r_out_sample;

    logic              w_out_free;
    logic              w_direct;
    logic              w_load;
    logic              w_finish;
    logic [RES_W-1:0]  w_prod1, w_prod2;
    logic [CODE_W:0]   w_t1, w_t2;
    logic              w_ge1, w_ge2;
    logic [RES_W-1:0]  w_res1, w_res2;
    t_res              w_direct_res;

    assign w_out_free = !r_out_valid || i_ready;

    // ticks without a computed quotient finish straight from the queue
    assign w_direct = (r_state == ST_IDLE) && i_q_valid && w_out_free &&
                      !(i_q_data.sample && (i_q_data.drop != '0));
    assign w_load   = (r_state == ST_IDLE) && i_q_valid &&
                      i_q_data.sample && (i_q_data.drop != '0);
    assign w_finish = (r_state == ST_DONE) && w_out_free;
    assign o_pop    = w_direct || w_load;

    assign w_prod1 = RES_W'(code_mag(r_cmd.sense_one)) * RES_W'(i_line_res);
    assign w_prod2 = RES_W'(code_mag(r_cmd.sense_two)) * RES_W'(i_line_res);

    assign w_t1  = {r_rem1, r_dvd1[MAG_W-1]};
    assign w_t2  = {r_rem2, r_dvd2[MAG_W-1]};
    assign w_ge1 = w_t1 >= {1'b0, r_dvs};
    assign w_ge2 = w_t2 >= {1'b0, r_dvs};

    assign w_res1 = r_neg1 ? (~{1'b0, r_dvd1} + RES_W'(1)) : {1'b0, r_dvd1};
    assign w_res2 = r_neg2 ? (~{1'b0, r_dvd2} + RES_W'(1)) : {1'b0, r_dvd2};

    always_comb begin
        w_direct_res.drive_a       = i_q_data.drive_a;
        w_direct_res.drive_b       = i_q_data.drive_b;
        w_direct_res.divide_error  = i_q_data.sample;
        w_direct_res.res_one_milli = '0;
        w_direct_res.res_two_milli = '0;
        w_direct_res.sense_one_out = i_q_data.sample ? i_q_data.sense_one : '0;
        w_direct_res.sense_two_out = i_q_data.sample ? i_q_data.sense_two : '0;
        w_direct_res.timestamp     = i_q_data.timestamp;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_load) n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_direct || w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd  <= i_q_data;
            r_dvs  <= code_mag(i_q_data.drop);
            r_neg1 <= i_q_data.sense_one[CODE_W-1] ^ i_q_data.drop[CODE_W-1];
            r_neg2 <= i_q_data.sense_two[CODE_W-1] ^ i_q_data.drop[CODE_W-1];
        end
        if (r_state == ST_MUL) begin
            r_dvd1 <= w_prod1[MAG_W-1:0];
            r_dvd2 <= w_prod2[MAG_W-1:0];
            r_rem1 <= '0;
            r_rem2 <= '0;
            r_step <= '0;
        end
        if (r_state == ST_DIV) begin
            r_rem1 <= w_ge1 ? CODE_W'(w_t1 - {1'b0, r_dvs}) : w_t1[CODE_W-1:0];
            r_rem2 <= w_ge2 ? CODE_W'(w_t2 - {1'b0, r_dvs}) : w_t2[CODE_W-1:0];
            r_dvd1 <= {r_dvd1[MAG_W-2:0], w_ge1};
            r_dvd2 <= {r_dvd2[MAG_W-2:0], w_ge2};
            r_step <= r_step + STEP_W'(1);
        end
        if (w_direct) begin
            r_out        <= w_direct_res;
            r_out_sample <= i_q_data.sample;
        end else if (w_finish) begin
            r_out.drive_a       <= r_cmd.drive_a;
            r_out.drive_b       <= r_cmd.drive_b;
            r_out.divide_error  <= 1'b0;
            r_out.res_one_milli <= w_res1;
            r_out.res_two_milli <= w_res2;
            r_out.sense_one_out <= r_cmd.sense_one;
            r_out.sense_two_out <= r_cmd.sense_two;
            r_out.timestamp     <= r_cmd.timestamp;
            r_out_sample        <= 1'b1;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_res    = r_out;
    assign o_sample = r_out_sample;

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_step < STEP_W'(DIV_STEPS))
        else $error("divider step counter out of range");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.divide_error |->
            r_out_sample && r_out.res_one_milli == '0 && r_out.res_two_milli == '0)
        else $error("divide error with nonzero resistance");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_pop)
        else $error("queue popped while datapath busy");
`endif

endmodule

`default_nettype wire

/* src/biphasic_excitation_resistance_meter.sv */
// ----------------------------------------------------------------------------
// biphasic_excitation_resistance_meter: h-bridge drive and resistance sampler
// one item per tick in, one result per tick out
// ----------------------------------------------------------------------------
// Each input item is one tick carrying the latest converter codes; each tick
// yields exactly one result with the bridge drive lines and, once per toggle
// period, a sample with two resistances r = sense * line_resistance / drop in
// milli-units (truncated toward zero, zero with divide_error when drop is 0).
// A tick without a computed sample passes straight from the queue to the
// result register. A sampling tick with nonzero drop occupies the back
// datapath through a dequeue, a multiply, 35 restoring division steps (one
// quotient bit per cycle, both resistances in parallel) and a load of the
// result register. A two-entry queue lets the input side keep taking ticks
// while a division runs, and the result register lets a new result form
// while the previous one waits. Configuration registers (APB, byte address
// 4*index): dc_mode, toggle_interval, sample_delay, line_resistance; write
// them only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module biphasic_excitation_resistance_meter import berm_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // apb configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [APB_W-1:0]       pwdata,
    output logic      [APB_W-1:0]       prdata,
    output logic                        pready,
    // tick items in
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // drop_code [15:0], sense_one_code [31:16], sense_two_code [47:32]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result items out
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // drive_a [0], drive_b [1], divide_error [2], res_one_milli [38:3],
    // res_two_milli [74:39], sense_one_out [90:75], sense_two_out [106:91],
    // timestamp [138:107], zero fill [143:139]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // sample_valid [0]
    output logic                        m_axis_tuser
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    // front to queue
    logic     w_push;
    t_cmd     w_cmd;
    logic     w_full;
    // queue to back
    logic     w_q_valid;
    t_cmd     w_q_data;
    logic     w_pop;
    t_res     w_res;

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dc_mode         <= 1'b0;
            r_cfg.toggle_interval <= TOGGLE_RST;
            r_cfg.sample_delay    <= DELAY_RST;
            r_cfg.line_resistance <= LINE_RES_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DC_MODE:         r_cfg.dc_mode         <= pwdata[0];
                REG_TOGGLE_INTERVAL: r_cfg.toggle_interval <= pwdata[INTERVAL_W-1:0];
                REG_SAMPLE_DELAY:    r_cfg.sample_delay    <= pwdata[DELAY_W-1:0];
                REG_LINE_RES:        r_cfg.line_resistance <= pwdata[LINE_RES_W-1:0];
                default:             r_cfg.dc_mode         <= r_cfg.dc_mode;
            endcase
        end
    end

    // register readback, zero extended
    always_comb begin
        unique case (w_idx)
            REG_DC_MODE:         prdata = APB_W'(r_cfg.dc_mode);
            REG_TOGGLE_INTERVAL: prdata = APB_W'(r_cfg.toggle_interval);
            REG_SAMPLE_DELAY:    prdata = APB_W'(r_cfg.sample_delay);
            REG_LINE_RES:        prdata = APB_W'(r_cfg.line_resistance);
            default:             prdata = '0;
        endcase
    end

    // ---------------- front: phase sequencing and sample decision ----------------
    berm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_drop       (s_axis_tdata[15:0]),
        .i_sense_one  (s_axis_tdata[31:16]),
        .i_sense_two  (s_axis_tdata[47:32]),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_cmd        (w_cmd)
    );

    // ---------------- command queue ----------------
    berm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // ---------------- back: multiply, divide, result register ----------------
    berm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_line_res (r_cfg.line_resistance),
        .i_q_valid  (w_q_valid),
        .i_q_data   (w_q_data),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (w_res),
        .o_sample   (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_W'(w_res);

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the biphasic excitation resistance meter
// ----------------------------------------------------------------------------
// Ticks go in on the slave stream, and readings come out on the master stream.
// Each accepted tick runs through a copy of the bridge, sample and divide
// behavior kept here. The expected reading is queued, and the checker compares
// every reading that comes out, field by field. Named tests cover register
// reset values, code extremes, zero settings, phase timing, the largest
// settings and randomized settings. Both streams idle at random.
// ----------------------------------------------------------------------------

module tb_top;
    import berm_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 50;    // a bit over one full division
    localparam int IDLE_PCT      = 21;

    localparam logic [CODE_W-1:0] CODE_EDGES [4] = '{16'h8000, 16'hFFFF, 16'h0001, 16'h7FFF};

    // one expected reading: the sample flag goes on tuser, the rest on tdata
    typedef struct packed {
        logic sampled;
        t_res fields;
    } t_tick_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [PADDR_W-1:0]     paddr         = '0;
    logic [APB_W-1:0]       pwdata        = '0;
    logic [APB_W-1:0]       prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // drop_code [15:0], sense_one_code [31:16], sense_two_code [47:32]
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // drive_a [0], drive_b [1], divide_error [2], res_one_milli [38:3],
    // res_two_milli [74:39], sense_one_out [90:75], sense_two_out [106:91],
    // timestamp [138:107], zero fill [143:139]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // sample_valid [0]
    logic                   m_axis_tuser;

    biphasic_excitation_resistance_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // register copies, kept in step with every write
    logic                  cfg_dc       = 1'b0;
    logic [INTERVAL_W-1:0] cfg_interval = TOGGLE_RST;
    logic [DELAY_W-1:0]    cfg_delay    = DELAY_RST;
    logic [LINE_RES_W-1:0] cfg_line     = LINE_RES_RST;

    // bridge and sampler state as the block should hold it
    logic [INTERVAL_W-1:0] interval_ticks    = '0;
    logic                  in_positive       = 1'b0;
    logic                  bridge_on         = 1'b0;
    logic                  sampled_in_period = 1'b0;
    logic [ELAPSED_W-1:0]  positive_age      = '0;
    logic                  stamp_running     = 1'b0;
    logic [TS_W-1:0]       stamp             = '0;

    t_tick_result expected_readings [$];
    int           fail_count  = 0;
    int           quiet_cycles = 0;
    bit           idle_on     = 1'b1;

    // sense * line / drop, truncated toward zero, kept to 36 bits
    function automatic logic [RES_W-1:0] milli_ohms(input logic signed [CODE_W-1:0] sense,
                                                    input logic signed [CODE_W-1:0] drop);
        longint product;
        product = longint'(sense) * longint'({1'b0, cfg_line});
        return RES_W'(product / longint'(drop));
    endfunction

    // advance the bridge by one tick and form the reading it gives
    function automatic t_tick_result predict_reading(input logic signed [CODE_W-1:0] drop,
                                                     input logic signed [CODE_W-1:0] sense_one,
                                                     input logic signed [CODE_W-1:0] sense_two);
        t_tick_result          r;
        logic [INTERVAL_W:0]   next_count;
        logic                  take;
        r = '0;
        next_count = {1'b0, interval_ticks} + (INTERVAL_W + 1)'(1);
        // an interval of zero fires on every tick, the same as one
        if (next_count >= {1'b0, cfg_interval}) begin
            interval_ticks = '0;
            bridge_on = 1'b1;
            if (cfg_dc) begin
                // dc drive: stay positive, age keeps running
                in_positive = 1'b1;
                sampled_in_period = 1'b0;
            end else begin
                in_positive = !in_positive;
                if (in_positive) begin
                    sampled_in_period = 1'b0;
                    positive_age = '0;
                end
            end
        end else begin
            interval_ticks = next_count[INTERVAL_W-1:0];
        end
        // age from before this tick's increment, so delay zero samples on the toggle
        take = !sampled_in_period && in_positive && (positive_age >= {1'b0, cfg_delay});
        r.fields.drive_a = bridge_on && in_positive;
        r.fields.drive_b = bridge_on && !in_positive;
        if (take) begin
            sampled_in_period = 1'b1;
            // first sample ever starts the timestamp at zero
            if (!stamp_running) begin
                stamp_running = 1'b1;
                stamp = '0;
            end
            r.sampled = 1'b1;
            if (drop == 0) begin
                r.fields.divide_error = 1'b1;
            end else begin
                r.fields.res_one_milli = milli_ohms(sense_one, drop);
                r.fields.res_two_milli = milli_ohms(sense_two, drop);
            end
            r.fields.sense_one_out = sense_one;
            r.fields.sense_two_out = sense_two;
            r.fields.timestamp     = stamp;
        end
        if (positive_age != ELAPSED_MAX)
            positive_age = positive_age + ELAPSED_W'(1);
        if (stamp_running)
            stamp = stamp + TS_W'(1);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [RES_W-1:0] want,
                                        input logic [RES_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // readings leave at the rising edge; compare with the oldest expectation
    always @(posedge i_clk) begin
        t_tick_result want;
        t_res         got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[OUT_BITS-1:0]);
            if (expected_readings.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected reading, expected none, got tdata %0h tuser %0b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_readings.pop_front();
                check_field("drive_a", RES_W'(want.fields.drive_a), RES_W'(got.drive_a));
                check_field("drive_b", RES_W'(want.fields.drive_b), RES_W'(got.drive_b));
                check_field("sample_valid", RES_W'(want.sampled), RES_W'(m_axis_tuser));
                check_field("divide_error", RES_W'(want.fields.divide_error),
                            RES_W'(got.divide_error));
                check_field("res_one_milli", want.fields.res_one_milli, got.res_one_milli);
                check_field("res_two_milli", want.fields.res_two_milli, got.res_two_milli);
                check_field("sense_one_out", RES_W'(want.fields.sense_one_out),
                            RES_W'(got.sense_one_out));
                check_field("sense_two_out", RES_W'(want.fields.sense_two_out),
                            RES_W'(got.sense_two_out));
                check_field("timestamp", RES_W'(want.fields.timestamp), RES_W'(got.timestamp));
            end
        end
    end

    // receiver stalls at random unless idling is switched off
    always @(negedge i_clk) begin
        m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // watchdog on cycles where nothing moves on any port
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // apb read: setup then access, data taken at the access edge
    task automatic reg_read(input t_reg_idx idx, output logic [APB_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(4 * int'(idx));
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input t_reg_idx idx, input logic [APB_W-1:0] want);
        logic [APB_W-1:0] got;
        reg_read(idx, got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: register %s reads wrong, expected %0h, got %0h",
                     $time, idx.name(), want, got);
        end
    endtask

    // apb write, then read back; only called with nothing in flight
    task automatic cfg_write(input t_reg_idx idx, input logic [APB_W-1:0] value);
        logic [APB_W-1:0] kept;
        case (idx)
            REG_DC_MODE:         kept = APB_W'(value[0]);
            REG_TOGGLE_INTERVAL: kept = APB_W'(value[INTERVAL_W-1:0]);
            REG_SAMPLE_DELAY:    kept = APB_W'(value[DELAY_W-1:0]);
            default:             kept = APB_W'(value[LINE_RES_W-1:0]);
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DC_MODE:         cfg_dc       = kept[0];
            REG_TOGGLE_INTERVAL: cfg_interval = kept[INTERVAL_W-1:0];
            REG_SAMPLE_DELAY:    cfg_delay    = kept[DELAY_W-1:0];
            default:             cfg_line     = kept[LINE_RES_W-1:0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_reg(idx, kept);
    endtask

    task automatic set_meter(input logic dc, input logic [INTERVAL_W-1:0] interval,
                             input logic [DELAY_W-1:0] delay,
                             input logic [LINE_RES_W-1:0] line);
        cfg_write(REG_DC_MODE, APB_W'(dc));
        cfg_write(REG_TOGGLE_INTERVAL, APB_W'(interval));
        cfg_write(REG_SAMPLE_DELAY, APB_W'(delay));
        cfg_write(REG_LINE_RES, APB_W'(line));
    endtask

    // offer one tick and hold it until taken; valid stays high on return
    task automatic send_tick(input logic [CODE_W-1:0] drop, input logic [CODE_W-1:0] sense_one,
                             input logic [CODE_W-1:0] sense_two);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sense_two, sense_one, drop};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_readings.push_back(predict_reading(drop, sense_one, sense_two));
        @(negedge i_clk);
    endtask

    // stop sending and wait out every reading still owed
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // drop codes lean on zero, tiny magnitudes and the range ends
    function automatic logic [CODE_W-1:0] pick_drop();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 25)
            return $urandom_range(0, 1) ? CODE_W'($urandom_range(1, 4))
                                        : -CODE_W'($urandom_range(1, 4));
        if (roll < 35)
            return CODE_EDGES[$urandom_range(0, 3)];
        return CODE_W'($urandom());
    endfunction

    function automatic logic [CODE_W-1:0] pick_sense();
        if ($urandom_range(0, 9) == 0)
            return CODE_EDGES[$urandom_range(0, 3)];
        return CODE_W'($urandom());
    endfunction

    // registers come up at their reset values and drives stay low
    task automatic test_reset_values;
        check_reg(REG_DC_MODE, '0);
        check_reg(REG_TOGGLE_INTERVAL, APB_W'(TOGGLE_RST));
        check_reg(REG_SAMPLE_DELAY, APB_W'(DELAY_RST));
        check_reg(REG_LINE_RES, APB_W'(LINE_RES_RST));
        repeat (4) send_tick(pick_drop(), pick_sense(), pick_sense());
        drain_results;
    endtask

    // dc drive with interval one samples every tick: walk the code extremes
    task automatic test_code_extremes;
        set_meter(1'b1, INTERVAL_W'(1), '0, '1);
        send_tick(16'h8000, 16'h7FFF, 16'h8000);
        send_tick(16'h8000, 16'h8000, 16'h7FFF);
        send_tick(16'h0001, 16'h7FFF, 16'h8000);
        send_tick(16'hFFFF, 16'h8000, 16'h7FFF);
        send_tick(16'h7FFF, 16'h0001, 16'hFFFF);
        send_tick(16'h0000, 16'h007B, 16'hFFFB);   // divide by zero
        send_tick(16'h0000, 16'h8000, 16'h7FFF);
        drain_results;
    endtask

    // zero line resistance, then zero interval with zero delay
    task automatic test_zero_settings;
        cfg_write(REG_LINE_RES, '0);
        repeat (3) send_tick(16'h0003, pick_sense(), pick_sense());
        drain_results;
        set_meter(1'b0, '0, '0, LINE_RES_W'(12345));
        repeat (4) send_tick(pick_drop(), pick_sense(), pick_sense());
        drain_results;
    endtask

    // biphasic drive: sample lands a fixed delay into the positive phase
    task automatic test_phase_timing;
        set_meter(1'b0, INTERVAL_W'(3), DELAY_W'(2), LINE_RES_W'(10000));
        repeat (8) send_tick(16'h0100, pick_sense(), pick_sense());
        drain_results;
    endtask

    // interval of 65536, widest delay, largest line resistance
    task automatic test_large_settings;
        set_meter(1'b0, INTERVAL_W'(65536), DELAY_W'(65535), '1);
        repeat (20) send_tick(pick_drop(), pick_sense(), pick_sense());
        drain_results;
        cfg_write(REG_DC_MODE, APB_W'(1));
        repeat (20) send_tick(pick_drop(), pick_sense(), pick_sense());
        drain_results;
    endtask

    // mostly short periods so samples come often, a few extreme settings
    task automatic test_random_settings;
        logic                  dc;
        logic [INTERVAL_W-1:0] interval;
        logic [DELAY_W-1:0]    delay;
        logic [LINE_RES_W-1:0] line;
        int unsigned           roll;
        for (int phase = 0; phase < 8; phase++) begin
            dc = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
            roll = $urandom_range(0, 9);
            interval = (roll < 7) ? INTERVAL_W'($urandom_range(1, 8)) :
                       (roll == 7) ? INTERVAL_W'($urandom_range(9, 40)) :
                       (roll == 8) ? '0 : INTERVAL_W'(65536);
            roll = $urandom_range(0, 9);
            delay = (roll < 7) ? DELAY_W'($urandom_range(0, 10)) :
                    (roll == 7) ? DELAY_W'($urandom_range(11, 60)) :
                    (roll == 8) ? '0 : '1;
            roll = $urandom_range(0, 9);
            line = (roll < 6) ? LINE_RES_W'($urandom_range(1, 20'hFFFFF)) :
                   (roll == 6) ? '0 :
                   (roll == 7) ? LINE_RES_W'(1) :
                   (roll == 8) ? '1 : LINE_RES_W'($urandom_range(1, 20000));
            set_meter(dc, interval, delay, line);
            // one phase runs with both streams at full speed
            idle_on = (phase != 3);
            for (int n = 0; n < 200; n++) begin
                send_tick(pick_drop(), pick_sense(), pick_sense());
                // hold off mid-phase until every reading has come back
                if (phase == 1 && n == 100)
                    drain_results;
            end
            drain_results;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values;
        test_code_extremes;
        test_zero_settings;
        test_phase_timing;
        test_large_settings;
        test_random_settings;
        if (expected_readings.size() != 0) begin
            fail_count++;
            $display("%0t: readings never delivered, expected 0 left, got %0d",
                     $time, expected_readings.size());
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
src/berm_pkg.sv
src/berm_front.sv
src/berm_queue.sv
src/berm_back.sv
src/biphasic_excitation_resistance_meter.sv
verif/tb_top.sv
